// ===== rtl/core/cooked_console_line_editor_macros.svh =====
// Assertion macros shared by the line editor RTL; they expect clock and reset in scope.
`ifndef COOKED_CONSOLE_LINE_EDITOR_MACROS_SVH
`define COOKED_CONSOLE_LINE_EDITOR_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CCLE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the trigger holds, the outcome must hold in the next cycle.
`define CCLE_ASSERT_NEXT(lbl, trig, outcome, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (outcome)) \
      else $error(msg);

`endif

// ===== rtl/core/ccle_pkg.sv =====
// Shared constants and types of the cooked console line editor.
`timescale 1ns / 1ps
package ccle_pkg;

   localparam int BYTE_W         = 8;
   localparam int CAP_W          = 7;
   localparam int LINE_DEPTH_DEF = 64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Control characters of the console.
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

   // Result queue depth and its occupancy width.
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_CW         = $clog2(RSP_FIFO_DEPTH + 1);

   // One result beat.
   typedef struct packed {
      logic              last;
      logic [BYTE_W-1:0] line_byte;
      logic              line_valid;
      logic [BYTE_W-1:0] echo_byte;
      logic              echo_valid;
   } rsp_item_type;

   // Status the result queue reports back to the controller.
   typedef struct packed {
      logic [RSP_CW-1:0] count;
      logic              has_room;
   } fifo_status_type;

endpackage

// ===== rtl/core/ccle_line_ram.sv =====
// Line store: one write port and one registered read port.
`timescale 1ns / 1ps
module ccle_line_ram #(
   parameter int DEPTH = ccle_pkg::LINE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [ccle_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [ccle_pkg::BYTE_W-1:0] rd_data
);
   import ccle_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ccle_rsp_fifo.sv =====
// Small result queue that decouples the editor from the result channel.
`timescale 1ns / 1ps
module ccle_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ccle_pkg::rsp_item_type        push_item,
   output ccle_pkg::fifo_status_type     status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output ccle_pkg::rsp_item_type        head_item
);
   import ccle_pkg::*;

   localparam int PW = $clog2(RSP_FIFO_DEPTH);

   rsp_item_type      slot_ff [RSP_FIFO_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0] count_ff, count_in;
   logic              pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   assign status.count    = count_ff;
   assign status.has_room = (count_ff < RSP_CW'(RSP_FIFO_DEPTH));

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CW'(push) - RSP_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/cooked_console_line_editor.sv =====
// Top level of the cooked console line editor: control, line store and result queue.
//
//   channel   direction  beat contents (low bit first)
//   req_*     in         tdata: rx_byte
//   rsp_*     out        tdata: echo_valid, echo_byte, line_valid, line_byte; tlast: last_of_run
//   csr_*     in         wdata: line_capacity (write only)
//
// A plain byte that fits in the line is accepted and yields its echo beat from the result queue.
// An erase on a non-empty line queues its three echo beats: backspace, space, backspace.
// A newline drains the stored line, ending in the newline when it fits, through the single
// read port of the line store, which sets the drain rate of one byte per cycle while the queue has room.
// Reset is synchronous; the line is empty afterward and needs no clearing pass.
// A stalled result side fills the four-entry queue and then holds off input and reads.
`timescale 1ns / 1ps
`include "cooked_console_line_editor_macros.svh"
module cooked_console_line_editor #(
   parameter int LINE_DEPTH = ccle_pkg::LINE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // [0] echo_valid, [8:1] echo_byte,
                                                     // [9] line_valid, [17:10] line_byte
   output logic                         rsp_tlast,   // last_of_run
   input  logic                         csr_wen,
   input  logic [ccle_pkg::CAP_W-1:0]   csr_wdata    // line_capacity
);
   import ccle_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int WW = ((CW > CAP_W) ? CW : CAP_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERASE,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       step_ff, step_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_first_ff, rd_first_in;
   logic             rd_last_ff, rd_last_in;
   logic [CAP_W-1:0] cap_ff, cap_in;

   logic [BYTE_W-1:0] rx_char;
   logic              is_erase;
   logic              is_lf;
   logic [WW-1:0]     cap_eff;
   logic              lf_room;
   logic              store_room;
   logic              accept;
   logic              issue;
   logic              push;
   rsp_item_type      push_item;
   rsp_item_type      head_item;
   fifo_status_type   fifo_status;
   logic              mem_we;
   logic [BYTE_W-1:0] mem_rdata;

   // Character decode; carriage return is treated as line feed.
   assign rx_char  = (req_tdata == CH_CR) ? CH_LF : req_tdata;
   assign is_erase = (rx_char == CH_BS) || (rx_char == CH_DEL);
   assign is_lf    = (rx_char == CH_LF);

   // Capacity above the store depth acts as the depth.
   always_comb begin
      cap_eff    = (WW'(cap_ff) > WW'(LINE_DEPTH)) ? WW'(LINE_DEPTH) : WW'(cap_ff);
      lf_room    = WW'(fill_ff) < cap_eff;
      store_room = (WW'(fill_ff) + WW'(1)) < cap_eff;
   end

   // Handshake and drain read issue, both gated by queue space.
   assign req_tready = (state_ff == ST_IDLE) && !rd_pend_ff && fifo_status.has_room;
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_DRAIN) &&
                       ((RSP_CW'(fifo_status.count) + RSP_CW'(rd_pend_ff))
                        < RSP_CW'(RSP_FIFO_DEPTH));

   // Line store write on an accepted byte that is kept.
   assign mem_we = accept && ((is_lf && lf_room) || (!is_erase && !is_lf && store_room));

   ccle_line_ram #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (rx_char),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   // Next state of the editor and the beat pushed into the queue.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      rd_pend_in  = issue;
      rd_first_in = rd_first_ff;
      rd_last_in  = rd_last_ff;
      cap_in      = csr_wen ? csr_wdata : cap_ff;
      push        = 1'b0;
      push_item   = '0;

      priority if (rd_pend_ff) begin
         // Line byte returned from the store.
         push                 = 1'b1;
         push_item.echo_valid = rd_first_ff;
         push_item.echo_byte  = rd_first_ff ? CH_LF : '0;
         push_item.line_valid = 1'b1;
         push_item.line_byte  = mem_rdata;
         push_item.last       = rd_last_ff;
      end else if (state_ff == ST_ERASE && fifo_status.has_room) begin
         // Backspace, space, backspace.
         push                 = 1'b1;
         push_item.echo_valid = 1'b1;
         push_item.echo_byte  = (step_ff == 2'd1) ? CH_SP : CH_BS;
         push_item.last       = (step_ff == 2'd2);
      end else if (accept) begin
         if (!is_erase && !is_lf && store_room) begin
            push                 = 1'b1;
            push_item.echo_valid = 1'b1;
            push_item.echo_byte  = rx_char;
            push_item.last       = 1'b1;
         end else if (is_lf && fill_ff == '0 && !lf_room) begin
            push                 = 1'b1;
            push_item.echo_valid = 1'b1;
            push_item.echo_byte  = CH_LF;
            push_item.last       = 1'b1;
         end
      end else begin
         // Nothing to queue this cycle.
         push = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_erase) begin
                  if (fill_ff != '0) begin
                     fill_in  = fill_ff - CW'(1);
                     step_in  = 2'd0;
                     state_in = ST_ERASE;
                  end
               end else if (is_lf) begin
                  fill_in = '0;
                  len_in  = fill_ff + CW'(lf_room);
                  idx_in  = '0;
                  if (fill_ff != '0 || lf_room) begin
                     state_in = ST_DRAIN;
                  end
               end else if (store_room) begin
                  fill_in = fill_ff + CW'(1);
               end
            end
         end
         ST_ERASE: begin
            if (push) begin
               step_in = step_ff + 2'd1;
               if (step_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               rd_first_in = (idx_ff == '0);
               rd_last_in  = (idx_ff + CW'(1) == len_ff);
               idx_in      = idx_ff + CW'(1);
               if (idx_ff + CW'(1) == len_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Editor state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         fill_ff    <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         cap_ff     <= CAP_RESET;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
         cap_ff     <= cap_in;
      end
   end

   // Tags that travel with a store read.
   always_ff @(posedge clock) begin
      rd_first_ff <= rd_first_in;
      rd_last_ff  <= rd_last_in;
   end

   ccle_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .status     (fifo_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head_item  (head_item)
   );

   // Result beat packing.
   assign rsp_tdata = {6'b0, head_item.line_byte, head_item.line_valid,
                       head_item.echo_byte, head_item.echo_valid};
   assign rsp_tlast = head_item.last;

   `CCLE_ASSERT_ALWAYS(a_fill_in_range, (WW'(fill_ff) <= WW'(LINE_DEPTH)), "fill beyond depth")
   `CCLE_ASSERT_ALWAYS(a_push_has_room, (!push || fifo_status.has_room), "push into full queue")
   `CCLE_ASSERT_ALWAYS(a_drain_index, (state_ff != ST_DRAIN || idx_ff < len_ff), "drain overrun")
   `CCLE_ASSERT_NEXT(a_erase_starts, (accept && is_erase && fill_ff != '0),
                     (state_ff == ST_ERASE && step_ff == 2'd0), "erase not started")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the cooked console line editor: keystrokes in, echo checks out.
`timescale 1ns / 1ps
module tb;
   import ccle_pkg::*;

   localparam int STORE_DEPTH = LINE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 130;
   localparam int QUIET_AFTER = 100;

   // Predicts the echo and line beats of each keystroke and checks them in order.
   class line_echo_checker;
      logic [BYTE_W-1:0] line_buf [STORE_DEPTH];
      int unsigned fill;
      int unsigned cap;
      rsp_item_type beats_due[$];
      int errors;

      function new();
         fill = 0;
         cap = 32'(CAP_RESET);
         errors = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         cap = 32'(value);
      endfunction

      function void push_beat(logic ev, logic [7:0] eb, logic lv, logic [7:0] lb, logic last);
         rsp_item_type beat;
         beat.echo_valid = ev;
         beat.echo_byte = eb;
         beat.line_valid = lv;
         beat.line_byte = lb;
         beat.last = last;
         beats_due.push_back(beat);
      endfunction

      // Notes one accepted keystroke and returns how many beats it causes.
      function int take_key(logic [BYTE_W-1:0] key);
         logic [BYTE_W-1:0] ch;
         int unsigned room;
         int unsigned n;
         ch = (key == CH_CR) ? CH_LF : key;
         room = (cap > STORE_DEPTH) ? STORE_DEPTH : cap;
         // Erase: backspace, space, backspace on a non-empty line.
         if (ch == CH_BS || ch == CH_DEL) begin
            if (fill == 0) return 0;
            fill--;
            push_beat(1'b1, CH_BS, 1'b0, 8'h00, 1'b0);
            push_beat(1'b1, CH_SP, 1'b0, 8'h00, 1'b0);
            push_beat(1'b1, CH_BS, 1'b0, 8'h00, 1'b1);
            return 3;
         end
         // Newline: store it if there is room, then drain the whole line.
         if (ch == CH_LF) begin
            n = fill;
            if (n < room) begin
               line_buf[n] = CH_LF;
               n++;
            end
            fill = 0;
            if (n == 0) begin
               push_beat(1'b1, CH_LF, 1'b0, 8'h00, 1'b1);
               return 1;
            end
            for (int k = 0; k < n; k++) begin
               push_beat(k == 0, (k == 0) ? CH_LF : 8'h00, 1'b1, line_buf[k], k + 1 == n);
            end
            return n;
         end
         // Ordinary byte: one slot always stays free for the newline.
         if (fill + 1 < room) begin
            line_buf[fill] = ch;
            fill++;
            push_beat(1'b1, ch, 1'b0, 8'h00, 1'b1);
            return 1;
         end
         return 0;
      endfunction

      // Compares one accepted result beat with the oldest prediction.
      function void match_beat(rsp_item_type got);
         rsp_item_type want;
         if (beats_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: ev=%0b eb=%h lv=%0b lb=%h last=%0b",
                        got.echo_valid, got.echo_byte, got.line_valid, got.line_byte, got.last);
            return;
         end
         want = beats_due.pop_front();
         if (got.echo_valid !== want.echo_valid || got.echo_byte !== want.echo_byte ||
             got.line_valid !== want.line_valid || got.line_byte !== want.line_byte ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display({"beat mismatch: expected ev=%0b eb=%h lv=%0b lb=%h last=%0b,",
                         " got ev=%0b eb=%h lv=%0b lb=%h last=%0b"},
                        want.echo_valid, want.echo_byte, want.line_valid, want.line_byte,
                        want.last, got.echo_valid, got.echo_byte, got.line_valid,
                        got.line_byte, got.last);
         end
      endfunction

      function int pending();
         return beats_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_wen;
   logic [CAP_W-1:0] csr_wdata;

   line_echo_checker checker_h;
   bit quiet;
   bit hold_rsp;
   int sent_keys;
   int cycle_count;

   cooked_console_line_editor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Result side: random stalls, plus one long hold when asked for.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Check every accepted result beat.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         checker_h.match_beat(rsp_item_type'({rsp_tlast, rsp_tdata[17:0]}));
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one keystroke, possibly after an idle burst, and waits until it is accepted.
   task automatic send_key(input logic [7:0] key);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = key;
      do @(posedge clock); while (!req_tready);
      sent_keys++;
      void'(checker_h.take_key(key));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Waits until every predicted beat has come and the block has settled.
   task automatic wait_idle();
      while (checker_h.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_idle();
      csr_wen = 1'b1;
      csr_wdata = value;
      checker_h.set_capacity(value);
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // Types one line of mostly printable text with some erases and noise.
   task automatic type_line(input int len, input bit terminate);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) send_key(8'($urandom_range(0, 255)));
         else if (r == 1) send_key($urandom_range(0, 1) ? CH_BS : CH_DEL);
         else send_key(8'($urandom_range(8'h20, 8'h7E)));
      end
      if (terminate) send_key($urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   initial begin
      int phase;
      int len;
      int r;
      checker_h = new();
      quiet = 1'b0;
      hold_rsp = 1'b0;
      sent_keys = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_wen = 1'b0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Erase on an empty line, extreme bytes, both erase codes, CR as newline.
      send_key(CH_BS);
      send_key(CH_DEL);
      send_key(8'h00);
      send_key(8'hFF);
      send_key(8'h41);
      send_key(CH_DEL);
      send_key(CH_BS);
      send_key(8'h7E);
      send_key(CH_CR);
      send_key(CH_LF);

      // Zero capacity: nothing stored, newline echoes alone.
      write_capacity(7'd0);
      send_key(8'h71);
      send_key(CH_LF);

      // Full line drops bytes silently.
      write_capacity(7'd3);
      send_key(8'h78);
      send_key(8'h79);
      send_key(8'h7A);
      send_key(CH_LF);

      // Capacity one leaves room for the newline only.
      write_capacity(7'd1);
      send_key(CH_LF);
      send_key(8'h6B);

      // Capacity lowered below the current fill keeps stored bytes.
      write_capacity(7'd64);
      for (int i = 0; i < 5; i++) send_key(8'(8'h61 + i));
      write_capacity(7'd2);
      send_key(8'h66);
      send_key(CH_LF);

      // Long stall on the result side while keystrokes keep coming.
      write_capacity(7'd64);
      @(negedge clock);
      hold_rsp = 1'b1;
      type_line(20, 1'b1);
      wait_idle();

      // Random phases, each under its own capacity; the first one overflows the store.
      phase = 0;
      while (sent_keys < ITEM_TARGET) begin
         if (sent_keys >= QUIET_AFTER) quiet = 1'b1;
         case (phase)
            0: write_capacity(7'd127);
            1: write_capacity(7'd65);
            2: write_capacity(7'd2);
            default: begin
               r = $urandom_range(0, 9);
               write_capacity(7'(r == 0 ? $urandom_range(0, 127) : $urandom_range(4, 40)));
            end
         endcase
         if (phase == 0) begin
            type_line(70, 1'b1);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 7) == 0) len = $urandom_range(20, 40);
               else len = $urandom_range(0, 10);
               type_line(len, $urandom_range(0, 9) != 0);
            end
         end
         phase++;
      end

      // Drain and settle before the verdict.
      while (checker_h.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (checker_h.errors == 0 && checker_h.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
